@@ design/trm_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types and constants for the register machine execute unit.
package trm_pkg;

    localparam int NUM_REGS_DEF  = 16;
    localparam int MEM_WORDS_DEF = 256;
    localparam int OPND_VALUES   = 256;
    localparam int PADDR_W       = 3;
    localparam logic [8:0] PROG_LEN_RST = 9'd256;

    localparam logic PADDR_PROG_LEN = 1'b0;

    localparam logic ACT_EXEC = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MV  = 4'd4,
        OP_ST  = 4'd5,
        OP_JMP = 4'd6,
        OP_JEQ = 4'd7,
        OP_JGT = 4'd8,
        OP_JLT = 4'd9,
        OP_W   = 4'd10,
        OP_R   = 4'd11,
        OP_STP = 4'd12
    } t_opcode;

    typedef struct packed {
        logic               action;
        logic [3:0]         opcode;
        logic [7:0]         operand_a;
        logic [7:0]         operand_b;
        logic [7:0]         operand_c;
        logic signed [31:0] input_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        next_pc;
        logic               halted;
        logic               print_valid;
        logic signed [31:0] print_value;
    } t_out_item;

endpackage

@@ design/trm_if.sv @@
`timescale 1ns / 1ps
// Interfaces: instruction input channel and result output channel.
interface trm_in_if;
    logic            valid;
    logic            ready;
    trm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface trm_out_if;
    logic             valid;
    logic             ready;
    trm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/toy_register_machine_execute_unit.sv @@
`timescale 1ns / 1ps
// Each item passes accept + memory read, execute and hand-off; MUL adds a multiply step, DIV the divider.
// DIV runs a radix-2 restoring divider, one quotient bit per cycle.
// Throughput: one item at a time; the next is accepted while a result waits in the output register.
// Reset (i_rst_n low, synchronous): pc 0, register file reads zero via valid bits,
// program_length 256, no result pending. Data memory is left uninitialised.
module toy_register_machine_execute_unit #(
    parameter int NUM_REGS  = trm_pkg::NUM_REGS_DEF,
    parameter int MEM_WORDS = trm_pkg::MEM_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    trm_in_if.sink                      i_in,
    trm_out_if.source                   o_out
);

    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MW = $clog2(MEM_WORDS);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE} t_state;

    // operand -> index tables, constant logic
    logic [RW-1:0] w_rmod [trm_pkg::OPND_VALUES];
    logic [MW-1:0] w_mmod [trm_pkg::OPND_VALUES];
    for (genvar g = 0; g < trm_pkg::OPND_VALUES; g++) begin : g_mod
        assign w_rmod[g] = RW'(g % NUM_REGS);
        assign w_mmod[g] = MW'(g % MEM_WORDS);
    end

    logic [31:0] rf   [NUM_REGS];
    logic [31:0] dmem [MEM_WORDS];
    logic [NUM_REGS-1:0] r_rf_valid;

    t_state      r_state;
    logic [8:0]  r_prog_len;
    logic [31:0] r_pc;

    logic        r_action;
    logic [3:0]  r_op;
    logic [RW-1:0] r_a_ridx;
    logic [MW-1:0] r_a_midx;
    logic [31:0] r_val;
    logic [31:0] r_rd0, r_rd1, r_mdata;
    logic        r_rd0_ok, r_rd1_ok;

    logic [31:0] r_prod;
    logic [31:0] r_div_rem, r_div_quo, r_div_md;
    logic        r_div_neg;
    logic [4:0]  r_div_cnt;

    logic [31:0] r_res_pc, r_res_pval;
    logic        r_res_halt, r_res_pv;

    logic        r_out_valid;
    trm_pkg::t_out_item r_out;

    // ---- config port ----
    logic w_cfg_wr;
    assign w_cfg_wr = psel & penable & pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == trm_pkg::PADDR_PROG_LEN) ? {23'd0, r_prog_len} : 32'd0;

    // ---- input side, read addresses ----
    logic w_accept, w_jcc_in;
    logic [RW-1:0] w_ra0, w_ra1;
    logic [MW-1:0] w_maddr;

    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign w_accept   = i_in.valid & i_in.ready;

    always_comb begin
        w_jcc_in = (i_in.data.opcode == trm_pkg::OP_JEQ) ||
                   (i_in.data.opcode == trm_pkg::OP_JGT) ||
                   (i_in.data.opcode == trm_pkg::OP_JLT);
        w_ra0 = w_jcc_in ? w_rmod[i_in.data.operand_a] : w_rmod[i_in.data.operand_b];
        w_ra1 = w_jcc_in ? w_rmod[i_in.data.operand_b] : w_rmod[i_in.data.operand_c];
        if (i_in.data.opcode == trm_pkg::OP_MV) begin
            w_maddr = w_mmod[i_in.data.operand_b];
        end else if (w_jcc_in) begin
            w_maddr = w_mmod[i_in.data.operand_c];
        end else begin
            w_maddr = w_mmod[i_in.data.operand_a];
        end
    end

    // ---- execute ----
    logic [31:0] w_op0, w_op1, w_inc, w_npc, w_mag0, w_mag1;
    logic        w_cond, w_halt, w_pv;
    logic        w_rf_we, w_dm_we;
    logic [31:0] w_rf_wdata, w_dm_wdata;
    logic [32:0] w_div_trial;
    logic [31:0] w_div_qnext;

    assign w_op0 = r_rd0_ok ? r_rd0 : 32'd0;
    assign w_op1 = r_rd1_ok ? r_rd1 : 32'd0;
    assign w_inc = r_pc + 32'd1;
    assign w_mag0 = w_op0[31] ? (32'd0 - w_op0) : w_op0;
    assign w_mag1 = w_op1[31] ? (32'd0 - w_op1) : w_op1;

    assign w_div_trial = {r_div_rem, r_div_quo[31]};
    assign w_div_qnext = {r_div_quo[30:0], (w_div_trial >= {1'b0, r_div_md})};

    always_comb begin
        w_cond = 1'b0;
        w_npc  = r_pc;
        w_pv   = 1'b0;
        if (r_action == trm_pkg::ACT_EXEC) begin
            unique case (r_op) inside
                trm_pkg::OP_ADD, trm_pkg::OP_SUB, trm_pkg::OP_MUL, trm_pkg::OP_DIV,
                trm_pkg::OP_MV, trm_pkg::OP_ST, trm_pkg::OP_W: begin
                    w_npc = w_inc;
                end
                trm_pkg::OP_R: begin
                    w_npc = w_inc;
                    w_pv  = 1'b1;
                end
                trm_pkg::OP_JMP: begin
                    w_npc = r_mdata;
                end
                trm_pkg::OP_JEQ, trm_pkg::OP_JGT, trm_pkg::OP_JLT: begin
                    if (r_op == trm_pkg::OP_JEQ) begin
                        w_cond = (w_op0 == w_op1);
                    end else if (r_op == trm_pkg::OP_JGT) begin
                        w_cond = ($signed(w_op0) > $signed(w_op1));
                    end else begin
                        w_cond = ($signed(w_op1) > $signed(w_op0));
                    end
                    w_npc = w_cond ? r_mdata : w_inc;
                end
                default: begin
                    w_npc = r_pc;
                end
            endcase
        end
        w_halt = ((r_action == trm_pkg::ACT_EXEC) && (r_op == trm_pkg::OP_STP)) ||
                 (w_npc >= {23'd0, r_prog_len}) || (w_npc >= 32'(MEM_WORDS));
    end

    // write-back to register file and data memory
    always_comb begin
        w_rf_we    = 1'b0;
        w_rf_wdata = 32'd0;
        w_dm_we    = 1'b0;
        w_dm_wdata = r_val;
        unique case (r_state)
            S_EXEC: begin
                if (r_action == trm_pkg::ACT_LOAD) begin
                    w_dm_we = 1'b1;
                end else begin
                    case (r_op)
                        trm_pkg::OP_ADD: begin
                            w_rf_we    = 1'b1;
                            w_rf_wdata = w_op0 + w_op1;
                        end
                        trm_pkg::OP_SUB: begin
                            w_rf_we    = 1'b1;
                            w_rf_wdata = w_op0 - w_op1;
                        end
                        trm_pkg::OP_DIV: begin
                            // divide by zero writes 0 here; otherwise the divider runs
                            w_rf_we    = (w_op1 == 32'd0);
                            w_rf_wdata = 32'd0;
                        end
                        trm_pkg::OP_MV: begin
                            w_rf_we    = 1'b1;
                            w_rf_wdata = r_mdata;
                        end
                        trm_pkg::OP_ST: begin
                            w_dm_we    = 1'b1;
                            w_dm_wdata = w_op0;
                        end
                        trm_pkg::OP_W: begin
                            w_dm_we = 1'b1;
                        end
                        default: begin
                            w_rf_we = 1'b0;
                        end
                    endcase
                end
            end
            S_MUL: begin
                w_rf_we    = 1'b1;
                w_rf_wdata = r_prod;
            end
            S_DIV: begin
                w_rf_we    = (r_div_cnt == 5'd31);
                w_rf_wdata = r_div_neg ? (32'd0 - w_div_qnext) : w_div_qnext;
            end
            default: begin
                w_rf_we = 1'b0;
            end
        endcase
    end

    // ---- memories ----
    always_ff @(posedge i_clk) begin
        if (w_rf_we) begin
            rf[r_a_ridx] <= w_rf_wdata;
        end
        if (w_accept) begin
            r_rd0    <= rf[w_ra0];
            r_rd1    <= rf[w_ra1];
            r_rd0_ok <= r_rf_valid[w_ra0];
            r_rd1_ok <= r_rf_valid[w_ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
        end else if (w_rf_we) begin
            r_rf_valid[r_a_ridx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dm_we) begin
            dmem[r_a_midx] <= w_dm_wdata;
        end
        if (w_accept) begin
            r_mdata <= dmem[w_maddr];
        end
    end

    // ---- payload capture and datapath registers ----
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_in.data.action;
            r_op     <= i_in.data.opcode;
            r_a_ridx <= w_rmod[i_in.data.operand_a];
            r_a_midx <= w_mmod[i_in.data.operand_a];
            r_val    <= i_in.data.input_value;
        end
        if (r_state == S_EXEC) begin
            r_prod     <= w_op0 * w_op1;
            r_div_rem  <= 32'd0;
            r_div_quo  <= w_mag0;
            r_div_md   <= w_mag1;
            r_div_neg  <= w_op0[31] ^ w_op1[31];
            r_res_pc   <= w_npc;
            r_res_halt <= w_halt;
            r_res_pv   <= w_pv;
            r_res_pval <= w_pv ? r_mdata : 32'd0;
        end else if (r_state == S_DIV) begin
            r_div_rem <= (w_div_trial >= {1'b0, r_div_md}) ?
                         32'(w_div_trial - {1'b0, r_div_md}) : w_div_trial[31:0];
            r_div_quo <= w_div_qnext;
        end
    end

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= 32'd0;
            r_prog_len  <= trm_pkg::PROG_LEN_RST;
            r_out_valid <= 1'b0;
            r_div_cnt   <= 5'd0;
        end else begin
            if (w_cfg_wr && paddr[2] == trm_pkg::PADDR_PROG_LEN) begin
                r_prog_len <= pwdata[8:0];
            end
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_pc      <= w_npc;
                    r_div_cnt <= 5'd0;
                    if (r_action == trm_pkg::ACT_EXEC && r_op == trm_pkg::OP_MUL) begin
                        r_state <= S_MUL;
                    end else if (r_action == trm_pkg::ACT_EXEC && r_op == trm_pkg::OP_DIV &&
                                 w_op1 != 32'd0) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    r_state <= S_DONE;
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == 5'd31) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out.next_pc     <= r_res_pc;
                        r_out.halted      <= r_res_halt;
                        r_out.print_valid <= r_res_pv;
                        r_out.print_value <= r_res_pval;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ---- assertions ----
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("item accepted while another is in flight");

    a_no_wb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rf_we || w_dm_we) |-> (r_state != S_IDLE && r_state != S_DONE))
        else $error("memory write outside execution");

    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.print_valid) |-> (o_out.data.print_value == 32'sd0))
        else $error("print value not zero without print_valid");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_div_cnt == 5'd31) |=> (r_state == S_DONE))
        else $error("divider did not finish after 32 steps");

endmodule
